>>> src/sgdm_pkg.sv
// Shared types, constants and fixed-point helpers for the SGD momentum update block.
package sgdm_pkg;

    localparam int VAL_W    = 32;
    localparam int IDX_W    = 16;
    localparam int SLOT_W   = 16;
    localparam int COEF_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = VAL_W + COEF_W + 1;
    localparam int SUM_W    = VAL_W + 4;

    localparam logic [COEF_W-1:0] LR_RESET  = 16'd655;
    localparam logic [COEF_W-1:0] MOM_RESET = 16'd58982;
    localparam logic [COEF_W-1:0] L2_RESET  = 16'd0;

    localparam logic [4:0] DECAY_SHIFT = 5'd15;
    localparam logic [4:0] COEF_SHIFT  = 5'd16;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LR  = 2'd0,
        CFG_MOM = 2'd1,
        CFG_L2  = 2'd2
    } cfg_reg_t;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [SLOT_W-1:0]       slot_t;
    typedef logic [COEF_W-1:0]       coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        val_t val;
        logic clip;
    } sat_res_t;

    // Stage B: decayed gradient ready, stored velocity read
    typedef struct packed {
        logic valid;
        idx_t idx;
        val_t w;
        val_t gd;
        logic clip;
        val_t vmem;
    } grad_stage_t;

    // Stage C: new velocity ready
    typedef struct packed {
        logic valid;
        idx_t idx;
        val_t w;
        val_t gd;
        logic clip;
        val_t vnew;
    } vel_stage_t;

    // Stage D: weight step product ready
    typedef struct packed {
        logic  valid;
        idx_t  idx;
        val_t  w;
        val_t  gd;
        logic  clip;
        val_t  vnew;
        prod_t prod;
    } step_stage_t;

    // Velocity of an item one stage further on, for bypass
    typedef struct packed {
        logic  valid;
        slot_t slot;
        val_t  vnew;
    } fwd_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
        val_t  data;
    } mem_wr_t;

    // Signed Q16.16 value times unsigned Q0.16 coefficient, exact
    function automatic prod_t mul_coef(input val_t v, input coef_t c);
        prod_t a;
        prod_t b;
        a = PROD_W'(v);
        b = PROD_W'({1'b0, c});
        return a * b;
    endfunction

    // Add half an LSB, then arithmetic shift: round half toward plus infinity
    function automatic sum_t round_shift(input prod_t p, input logic [4:0] sh);
        prod_t half;
        prod_t q;
        half = $signed(PROD_W'(1) << (sh - 5'd1));
        q = p + half;
        q = q >>> sh;
        return $signed(q[SUM_W-1:0]);
    endfunction

    function automatic sat_res_t sat_val(input sum_t x);
        sat_res_t r;
        if (x > SAT_HI)
        begin
            r.val  = SAT_HI[VAL_W-1:0];
            r.clip = 1'b1;
        end
        else if (x < SAT_LO)
        begin
            r.val  = SAT_LO[VAL_W-1:0];
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = x[VAL_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> src/sgdm_vel_mem.sv
// Velocity store: one write port, one registered read port, zeroing sweep after reset.
module sgdm_vel_mem import sgdm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rd_en,
    input  slot_t   rd_addr,
    output val_t    rd_data,
    input  mem_wr_t wr,
    output logic    clearing
);

    val_t  mem [2**SLOT_W];
    val_t  rd_data_reg;
    slot_t clr_cnt_reg;
    slot_t clr_cnt_next;
    logic  clearing_reg;
    logic  clearing_next;
    logic  we;
    slot_t wa;
    val_t  wd;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next  = clr_cnt_reg + slot_t'(1);
            clearing_next = (clr_cnt_reg != {SLOT_W{1'b1}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    assign we = clearing_reg | wr.en;
    assign wa = clearing_reg ? clr_cnt_reg : wr.addr;
    assign wd = clearing_reg ? '0 : wr.data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

>>> src/sgdm_decay_stage.sv
// Stages A and B: weight decay product, then decayed and saturated gradient.
module sgdm_decay_stage import sgdm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        load,
    input  idx_t        idx_in,
    input  val_t        w_in,
    input  val_t        g_in,
    input  coef_t       l2,
    input  val_t        vmem,
    output grad_stage_t b
);

    logic        a_valid_reg;
    idx_t        a_idx_reg;
    val_t        a_w_reg;
    val_t        a_g_reg;
    prod_t       a_prod_reg;
    grad_stage_t b_reg;
    grad_stage_t b_next;
    sum_t        gd_sum;
    sat_res_t    gd_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_idx_reg  <= idx_in;
            a_w_reg    <= w_in;
            a_g_reg    <= g_in;
            a_prod_reg <= mul_coef(w_in, l2);
        end
    end

    // decay = round(w * l2 / 2^15), i.e. 2*l2*w
    always_comb
    begin
        gd_sum      = SUM_W'(a_g_reg) + round_shift(a_prod_reg, DECAY_SHIFT);
        gd_sat      = sat_val(gd_sum);
        b_next.valid = a_valid_reg;
        b_next.idx   = a_idx_reg;
        b_next.w     = a_w_reg;
        b_next.gd    = gd_sat.val;
        b_next.clip  = gd_sat.clip;
        b_next.vmem  = vmem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (advance)
        begin
            b_reg <= b_next;
        end
    end

    assign b = b_reg;

endmodule

>>> src/sgdm_vel_stage.sv
// Stage C: velocity update with bypass from younger writes, and store write-back.
module sgdm_vel_stage import sgdm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  grad_stage_t b,
    input  coef_t       mom,
    input  fwd_t        fwd,
    output vel_stage_t  c,
    output mem_wr_t     wr
);

    vel_stage_t c_reg;
    vel_stage_t c_next;
    slot_t      slot;
    val_t       vold;
    sum_t       v_sum;
    sat_res_t   v_sat;

    assign slot = b.idx[SLOT_W-1:0];

    // The store read missed the two items just ahead; take the newest match
    always_comb
    begin
        priority if (c_reg.valid && (c_reg.idx[SLOT_W-1:0] == slot))
        begin
            vold = c_reg.vnew;
        end
        else if (fwd.valid && (fwd.slot == slot))
        begin
            vold = fwd.vnew;
        end
        else
        begin
            vold = b.vmem;
        end
    end

    always_comb
    begin
        v_sum        = round_shift(mul_coef(vold, mom), COEF_SHIFT) + SUM_W'(b.gd);
        v_sat        = sat_val(v_sum);
        c_next.valid = b.valid;
        c_next.idx   = b.idx;
        c_next.w     = b.w;
        c_next.gd    = b.gd;
        c_next.clip  = b.clip | v_sat.clip;
        c_next.vnew  = v_sat.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
        end
        else if (advance)
        begin
            c_reg <= c_next;
        end
    end

    assign wr.en   = advance & b.valid;
    assign wr.addr = slot;
    assign wr.data = v_sat.val;
    assign c       = c_reg;

endmodule

>>> src/sgdm_weight_stage.sv
// Stages D and E: learning-rate step product, then saturated weight into the output register.
module sgdm_weight_stage import sgdm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  vel_stage_t c,
    input  coef_t      lr,
    output fwd_t       fwd,
    output logic       out_valid,
    output idx_t       out_idx,
    output val_t       out_w,
    output val_t       out_gd,
    output logic       out_sat
);

    step_stage_t d_reg;
    step_stage_t d_next;
    sum_t        w_sum;
    sat_res_t    w_sat;
    logic        out_valid_reg;
    idx_t        out_idx_reg;
    val_t        out_w_reg;
    val_t        out_gd_reg;
    logic        out_sat_reg;

    always_comb
    begin
        d_next.valid = c.valid;
        d_next.idx   = c.idx;
        d_next.w     = c.w;
        d_next.gd    = c.gd;
        d_next.clip  = c.clip;
        d_next.vnew  = c.vnew;
        d_next.prod  = mul_coef(c.vnew, lr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (advance)
        begin
            d_reg <= d_next;
        end
    end

    assign fwd.valid = d_reg.valid;
    assign fwd.slot  = d_reg.idx[SLOT_W-1:0];
    assign fwd.vnew  = d_reg.vnew;

    always_comb
    begin
        w_sum = SUM_W'(d_reg.w) - round_shift(d_reg.prod, COEF_SHIFT);
        w_sat = sat_val(w_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= d_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_idx_reg <= d_reg.idx;
            out_w_reg   <= w_sat.val;
            out_gd_reg  <= d_reg.gd;
            out_sat_reg <= d_reg.clip | w_sat.clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_idx   = out_idx_reg;
    assign out_w     = out_w_reg;
    assign out_gd    = out_gd_reg;
    assign out_sat   = out_sat_reg;

endmodule

>>> src/sgd_momentum_param_update.sv
// Top level of the SGD-with-momentum weight update pipeline.
//
// Input channel (in_valid / in_stall) takes one weight per item: element_index,
// weight_in and gradient_in. Output channel (out_valid / out_stall) returns
// index_out, weight_out, decayed_gradient and the saturated flag, one result per
// item, in order. Configuration writes go through cfg_valid / cfg_ready with
// cfg_index (0 learning rate, 1 momentum, 2 L2 decay) and cfg_data; write them
// only while no item is in flight.
// Throughput is one item per cycle while the pipeline is not held. Five register
// stages (decay product, decayed gradient, velocity, step product, output
// register) lie between the edge that accepts an item and its result on the
// output. The velocity loop closes through bypass: an item whose store read is
// stale takes the newer value from the two stages ahead.
// After reset the velocity store is swept to zero, one entry per cycle:
// in_stall stays high until the sweep is done; configuration writes are taken as ever.
// When out_stall holds a waiting result, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is lost or repeated.
module sgd_momentum_param_update import sgdm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IDX_W-1:0]     element_index,
    input  logic signed [VAL_W-1:0] weight_in,
    input  logic signed [VAL_W-1:0] gradient_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [IDX_W-1:0]     index_out,
    output logic signed [VAL_W-1:0] weight_out,
    output logic signed [VAL_W-1:0] decayed_gradient,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    coef_t       lr_reg;
    coef_t       mom_reg;
    coef_t       l2_reg;
    logic        advance;
    logic        accept;
    logic        clearing;
    val_t        vmem;
    grad_stage_t b;
    vel_stage_t  c;
    fwd_t        fwd;
    mem_wr_t     wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg  <= LR_RESET;
            mom_reg <= MOM_RESET;
            l2_reg  <= L2_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LR:  lr_reg  <= cfg_data;
                CFG_MOM: mom_reg <= cfg_data;
                CFG_L2:  l2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold every stage while a result waits on a stalled receiver
    assign advance  = ~(out_valid & out_stall);
    assign in_stall = ~advance | clearing;
    assign accept   = in_valid & ~in_stall;

    sgdm_vel_mem u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (advance),
        .rd_addr  (element_index[SLOT_W-1:0]),
        .rd_data  (vmem),
        .wr       (wr),
        .clearing (clearing)
    );

    sgdm_decay_stage u_decay (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .load    (accept),
        .idx_in  (element_index),
        .w_in    (weight_in),
        .g_in    (gradient_in),
        .l2      (l2_reg),
        .vmem    (vmem),
        .b       (b)
    );

    sgdm_vel_stage u_vel (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .b       (b),
        .mom     (mom_reg),
        .fwd     (fwd),
        .c       (c),
        .wr      (wr)
    );

    sgdm_weight_stage u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .c         (c),
        .lr        (lr_reg),
        .fwd       (fwd),
        .out_valid (out_valid),
        .out_idx   (index_out),
        .out_w     (weight_out),
        .out_gd    (decayed_gradient),
        .out_sat   (saturated)
    );

endmodule
